@@ hw/rtl/trp_pkg.sv @@
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and constants for the Theora RTP packetizer: header layout,
// fragment type codes, register indexes and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package trp_pkg;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_PAYLOAD  = 1'b0,
		REG_CONFIG_IDENT = 1'b1
	} reg_idx_t;

	// Register reset values.
	localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd900;
	localparam logic [23:0] CONFIG_IDENT_RST = 24'h011983;

	// Frame length is never wider than this, whatever the port width.
	localparam int unsigned FLEN_MAX_BITS = 24;

	// Fragment type codes carried in the top two bits of header byte 3.
	typedef enum logic [1:0] {
		FT_NONE  = 2'd0,
		FT_START = 2'd1,
		FT_CONT  = 2'd2,
		FT_END   = 2'd3
	} ftype_t;

	// Header byte slots; the payload byte follows the last of them.
	localparam int unsigned SLOT_W = 3;
	typedef enum logic [SLOT_W-1:0] {
		SLOT_ID_HI   = 3'd0,
		SLOT_ID_MID  = 3'd1,
		SLOT_ID_LO   = 3'd2,
		SLOT_FLAGS   = 3'd3,
		SLOT_LEN_HI  = 3'd4,
		SLOT_LEN_LO  = 3'd5,
		SLOT_PAYLOAD = 3'd6
	} slot_t;

	// One classified frame byte, as passed from the front to the back.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        pkt_start;
		logic [23:0] ident;
		logic [7:0]  flags;
		logic [15:0] len;
		logic        packet_end;
		logic        frame_end;
	} entry_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Queue depth.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

endpackage

`default_nettype wire

@@ hw/rtl/trp_front.sv @@
// ----------------------------------------------------------------------------
// trp_front
// Accepts frame bytes, tracks frame and packet progress, and works out for
// each byte whether it opens a packet and what that packet's header holds.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_front #(
	parameter int unsigned FRAME_LEN_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration writes.
	input  wire logic                            cfg_we,
	input  wire logic [trp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [trp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Incoming frame byte.
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      data_byte,
	input  wire logic [1:0]                      payload_type,
	input  wire logic [FRAME_LEN_BITS-1:0]       frame_length,
	// Queue push side.
	input  wire trp_pkg::fifo_stat_t             fifo_stat,
	output logic                                 push,
	output trp_pkg::entry_t                      push_entry
);
	import trp_pkg::*;

	localparam int unsigned FL_EFF_BITS =
		(FRAME_LEN_BITS < FLEN_MAX_BITS) ? FRAME_LEN_BITS : FLEN_MAX_BITS;

	// Configuration registers.
	logic [15:0]               max_payload_q;
	logic [23:0]               config_ident_q;

	// Frame progress.
	logic [FRAME_LEN_BITS-1:0] frame_left_q;
	logic [15:0]               chunk_left_q;
	logic                      frag_q;
	logic                      first_q;

	logic [FRAME_LEN_BITS-1:0] flen_m;
	logic [FRAME_LEN_BITS-1:0] flen_eff;
	logic [15:0]               maxp;
	logic [FRAME_LEN_BITS-1:0] maxp_x;
	logic                      new_frame;
	logic [FRAME_LEN_BITS-1:0] frame_cur;
	logic                      frag_cur;
	logic                      first_cur;
	logic [15:0]               chunk_cur;
	logic                      start;
	logic [15:0]               len;
	ftype_t                    ftype;
	logic [15:0]               chunk_next;
	logic [FRAME_LEN_BITS-1:0] frame_next;
	logic                      fend;
	logic                      pend;
	logic                      accept;

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	// Effective length and packet size; zero is taken as one.
	always_comb begin
		flen_m   = FRAME_LEN_BITS'(frame_length[FL_EFF_BITS-1:0]);
		flen_eff = (flen_m == '0) ? FRAME_LEN_BITS'(1) : flen_m;
		maxp     = (max_payload_q == '0) ? 16'd1 : max_payload_q;
		maxp_x   = FRAME_LEN_BITS'(maxp);
	end

	// Frame start takes over the length and fixes the fragmentation decision.
	always_comb begin
		new_frame = (frame_left_q == '0);
		frame_cur = new_frame ? flen_eff : frame_left_q;
		frag_cur  = new_frame ? (flen_eff > maxp_x) : frag_q;
		first_cur = new_frame ? 1'b1 : first_q;
		chunk_cur = new_frame ? 16'd0 : chunk_left_q;
		start     = (chunk_cur == '0);
		len       = (frame_cur < maxp_x) ? frame_cur[15:0] : maxp;
	end

	// Fragment type for a packet that opens here.
	always_comb begin
		if (!frag_cur) begin
			ftype = FT_NONE;
		end else if (first_cur) begin
			ftype = FT_START;
		end else if (frame_cur <= maxp_x) begin
			ftype = FT_END;
		end else begin
			ftype = FT_CONT;
		end
	end

	// Counters after this byte and its end marks.
	always_comb begin
		chunk_next = (start ? len : chunk_cur) - 16'd1;
		frame_next = frame_cur - FRAME_LEN_BITS'(1);
		fend       = (frame_next == '0);
		pend       = (chunk_next == '0) || fend;
	end

	// Queue entry.
	always_comb begin
		push_entry.data_byte  = data_byte;
		push_entry.pkt_start  = start;
		push_entry.ident      = config_ident_q;
		push_entry.flags      = {ftype, payload_type, 3'b000, !frag_cur};
		push_entry.len        = len;
		push_entry.packet_end = pend;
		push_entry.frame_end  = fend;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q  <= MAX_PAYLOAD_RST;
			config_ident_q <= CONFIG_IDENT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_PAYLOAD:  max_payload_q  <= cfg_data[15:0];
				REG_CONFIG_IDENT: config_ident_q <= cfg_data[23:0];
				default:          ;
			endcase
		end
	end

	// Frame progress state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_left_q <= '0;
			chunk_left_q <= '0;
			frag_q       <= 1'b0;
			first_q      <= 1'b1;
		end else if (accept) begin
			frame_left_q <= frame_next;
			chunk_left_q <= fend ? 16'd0 : chunk_next;
			frag_q       <= frag_cur;
			first_q      <= start ? 1'b0 : first_cur;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/trp_fifo.sv @@
// ----------------------------------------------------------------------------
// trp_fifo
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire trp_pkg::entry_t push_entry,
	input  wire logic            pop,
	output trp_pkg::entry_t      head,
	output trp_pkg::fifo_stat_t  stat
);
	import trp_pkg::*;

	entry_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_PTR_W:0]     count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (FIFO_PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/trp_back.sv @@
// ----------------------------------------------------------------------------
// trp_back
// Turns each queued byte into output words: the six header bytes when it
// opens a packet, then the payload byte itself, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire trp_pkg::entry_t head,
	input  wire trp_pkg::fifo_stat_t fifo_stat,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic                 packet_end,
	output logic                 frame_end,
	output logic                 run_end
);
	import trp_pkg::*;

	logic [SLOT_W-1:0] slot_q;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic              pend_q;
	logic              fend_q;
	logic              last_q;

	slot_t             slot;
	logic              load;
	logic              is_pay;
	logic [7:0]        byte_d;

	assign load   = !fifo_stat.empty && (!valid_q || out_ready);
	assign slot   = head.pkt_start ? slot_t'(slot_q) : SLOT_PAYLOAD;
	assign is_pay = (slot == SLOT_PAYLOAD);
	assign pop    = load && is_pay;

	// Pick the byte for the current slot.
	always_comb begin
		case (slot)
			SLOT_ID_HI:  byte_d = head.ident[23:16];
			SLOT_ID_MID: byte_d = head.ident[15:8];
			SLOT_ID_LO:  byte_d = head.ident[7:0];
			SLOT_FLAGS:  byte_d = head.flags;
			SLOT_LEN_HI: byte_d = head.len[15:8];
			SLOT_LEN_LO: byte_d = head.len[7:0];
			default:     byte_d = head.data_byte;
		endcase
	end

	// Slot counter and output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			slot_q  <= is_pay ? '0 : slot_q + SLOT_W'(1);
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output word.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			pend_q <= is_pay && head.packet_end;
			fend_q <= is_pay && head.frame_end;
			last_q <= is_pay;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign packet_end = pend_q;
	assign frame_end  = fend_q;
	assign run_end    = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/theora_rtp_packetizer_core.sv @@
// ----------------------------------------------------------------------------
// theora_rtp_packetizer_core
// Theora RTP payload packetizer: frame bytes in, packets with headers out.
// ----------------------------------------------------------------------------
// Each frame byte taken on the slave side yields one output word, or seven
// when it opens a packet: three bytes of configuration ident, a byte of
// fragment type, data type and packet count, a big-endian 16-bit length, and
// then the byte itself. The output port moves one word per cycle while the
// sink is ready; the output register sets the pace. cfg_ready is always high.
// The front classifies a byte in the cycle it arrives and can take one every
// cycle while its four-entry queue has room. tlast marks the last word caused
// by an input byte; tuser carries the packet and frame end marks. The user
// must write configuration only while the block is idle; nothing enforces it.
`default_nettype none

module theora_rtp_packetizer_core #(
	parameter int unsigned FRAME_LEN_BITS = 24
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Configuration write channel.
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [trp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [trp_pkg::CFG_DATA_W-1:0]        cfg_data,
	// Frame bytes in.
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// tdata: data_byte [7:0], frame_length [8 +: FRAME_LEN_BITS], zero pad
	input  wire logic [((8 + FRAME_LEN_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// tuser: payload_type [1:0]
	input  wire logic [1:0]                            s_tuser,
	// Packet stream out.
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// tdata: out_byte [7:0]
	output logic [7:0]                                 m_tdata,
	// tuser: packet_end [0], frame_end [1]
	output logic [1:0]                                 m_tuser,
	output logic                                       m_tlast
);
	import trp_pkg::*;

	fifo_stat_t fifo_stat;
	entry_t     push_entry;
	entry_t     head;
	logic       push;
	logic       pop;
	logic       pend;
	logic       fend;

	assign cfg_ready = 1'b1;

	// Front: classification and header values.
	trp_front #(
		.FRAME_LEN_BITS (FRAME_LEN_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.data_byte    (s_tdata[7:0]),
		.payload_type (s_tuser),
		.frame_length (s_tdata[8 +: FRAME_LEN_BITS]),
		.fifo_stat    (fifo_stat),
		.push         (push),
		.push_entry   (push_entry)
	);

	// Queue between the two parts.
	trp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (fifo_stat)
	);

	// Back: header insertion and output register.
	trp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_stat  (fifo_stat),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.packet_end (pend),
		.frame_end  (fend),
		.run_end    (m_tlast)
	);

	assign m_tuser = {fend, pend};

	// The back only takes an entry the queue holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("queue popped while empty");

	// The front never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_stat.full)
		else $error("queue pushed while full");

	// Header words carry no end marks.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == 2'b00))
		else $error("end mark on a header word");

	// A frame end is always a packet end.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tuser[0])
		else $error("frame end without packet end");

endmodule

`default_nettype wire

@@ bench/tb_theora_rtp_packetizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_theora_rtp_packetizer_core
// Self-checking bench for the Theora RTP packetizer core.
// ----------------------------------------------------------------------------
// Frame bytes are queued by the stimulus process and presented by a clocked
// driver. The bench keeps its own model of the packetizer. For every frame
// byte accepted on the slave side, that model works out the header and
// payload words it should cause. A clocked monitor compares every word
// accepted on the master side with the oldest word still due. Registers are
// rewritten between phases while the core is idle, and both sides of the
// stream stall in random bursts. The sink also holds off once for a long
// stretch, so that the core fills up.
module tb_theora_rtp_packetizer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import trp_pkg::*;

	localparam int unsigned FLEN_W    = 24;
	localparam int unsigned S_TDATA_W = ((8 + FLEN_W + 7) / 8) * 8;

	// One frame byte as offered on the slave side.
	typedef struct packed {
		logic [7:0]        data;
		logic [1:0]        ptype;
		logic [FLEN_W-1:0] flen;
	} frame_byte_t;

	// One word of the packet stream.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       frame_end;
		logic       last;
	} pkt_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_idx_t              cfg_index = REG_MAX_PAYLOAD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	theora_rtp_packetizer_core #(
		.FRAME_LEN_BITS(FLEN_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Bench copy of the registers and of the packetizer state.
	logic [15:0]       max_payload_q = MAX_PAYLOAD_RST;
	logic [23:0]       ident_q       = CONFIG_IDENT_RST;
	logic [FLEN_W-1:0] frame_left    = '0;
	logic [15:0]       chunk_left    = '0;
	logic              fragmented    = 1'b0;
	logic              first_packet  = 1'b1;

	frame_byte_t byte_queue[$];
	pkt_word_t   due_words[$];

	logic in_acc  = 1'b0;
	logic hold_on = 1'b0;
	logic calm    = 1'b0;
	int   src_pct = 0;
	int   snk_pct = 0;
	int   src_gap = 0;
	int   snk_gap = 0;

	int errors       = 0;
	int bytes_sent   = 0;
	int words_seen   = 0;
	int packets_seen = 0;
	int frames_seen  = 0;
	int settings     = 1;

	// Work out the words that one accepted frame byte causes.
	task automatic packetize_byte(input logic [7:0] data, input logic [1:0] ptype,
			input logic [FLEN_W-1:0] flen);
		logic [15:0]       maxp;
		logic [FLEN_W-1:0] fl;
		logic [15:0]       len;
		ftype_t            ft;
		logic [7:0]        flags;
		logic              pend;
		logic              fend;
		maxp = (max_payload_q == 16'd0) ? 16'd1 : max_payload_q;
		// A new frame starts; a zero length counts as a single byte.
		if (frame_left == '0) begin
			fl = (flen == '0) ? FLEN_W'(1) : flen;
			frame_left   = fl;
			fragmented   = fl > FLEN_W'(maxp);
			first_packet = 1'b1;
			chunk_left   = '0;
		end
		// A new packet starts: six header bytes ahead of the payload byte.
		if (chunk_left == '0) begin
			len = (frame_left < FLEN_W'(maxp)) ? frame_left[15:0] : maxp;
			if (!fragmented)
				ft = FT_NONE;
			else if (first_packet)
				ft = FT_START;
			else if (frame_left <= FLEN_W'(maxp))
				ft = FT_END;
			else
				ft = FT_CONT;
			flags = {ft, ptype, 3'b000, ~fragmented};
			first_packet = 1'b0;
			chunk_left   = len;
			due_words.push_back('{ident_q[23:16], 1'b0, 1'b0, 1'b0});
			due_words.push_back('{ident_q[15:8], 1'b0, 1'b0, 1'b0});
			due_words.push_back('{ident_q[7:0], 1'b0, 1'b0, 1'b0});
			due_words.push_back('{flags, 1'b0, 1'b0, 1'b0});
			due_words.push_back('{len[15:8], 1'b0, 1'b0, 1'b0});
			due_words.push_back('{len[7:0], 1'b0, 1'b0, 1'b0});
		end
		chunk_left = chunk_left - 16'd1;
		frame_left = frame_left - FLEN_W'(1);
		pend = chunk_left == '0;
		fend = frame_left == '0;
		if (fend)
			chunk_left = '0;
		due_words.push_back('{data, pend | fend, fend, 1'b1});
	endtask

	// Slave-side sampling and prediction, master-side checking.
	always @(posedge clk) begin : monitor
		pkt_word_t w;
		in_acc <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			packetize_byte(s_tdata[7:0], s_tuser, s_tdata[8 +: FLEN_W]);
			bytes_sent++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word: tdata %02h tuser %b tlast %b",
					$realtime, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				w = due_words.pop_front();
				if (m_tdata !== w.out_byte) begin
					$display("%0t: out_byte expected %02h actual %02h",
						$realtime, w.out_byte, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== w.packet_end) begin
					$display("%0t: packet_end expected %b actual %b",
						$realtime, w.packet_end, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== w.frame_end) begin
					$display("%0t: frame_end expected %b actual %b",
						$realtime, w.frame_end, m_tuser[1]);
					errors++;
				end
				if (m_tlast !== w.last) begin
					$display("%0t: tlast expected %b actual %b",
						$realtime, w.last, m_tlast);
					errors++;
				end
				if (w.packet_end)
					packets_seen++;
				if (w.frame_end)
					frames_seen++;
			end
		end
	end

	// Slave-side driver: holds a word until it is taken, with random gaps.
	always @(negedge clk) begin : drive_bytes
		logic        valid_n;
		frame_byte_t item;
		valid_n = 1'b0;
		if (!arst_n) begin
			valid_n = 1'b0;
		end else if (s_tvalid && !in_acc) begin
			valid_n = 1'b1;
		end else if (!calm && src_gap > 0) begin
			src_gap--;
		end else if (byte_queue.size() == 0) begin
			valid_n = 1'b0;
		end else if (!calm && src_pct != 0 && $urandom_range(99) < src_pct) begin
			src_gap = $urandom_range(8);
		end else begin
			item = byte_queue.pop_front();
			s_tdata <= S_TDATA_W'({item.flen, item.data});
			s_tuser <= item.ptype;
			valid_n = 1'b1;
		end
		s_tvalid <= valid_n;
	end

	// Master-side ready: random stall bursts and the long hold-off.
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_on) begin
			m_tready <= 1'b0;
		end else if (!calm && snk_gap > 0) begin
			m_tready <= 1'b0;
			snk_gap--;
		end else if (!calm && snk_pct != 0 && $urandom_range(99) < snk_pct) begin
			m_tready <= 1'b0;
			snk_gap = $urandom_range(8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Long sink hold-off while the source keeps offering bytes.
	initial begin : sink_hold
		wait (bytes_sent >= 105);
		@(posedge clk);
		hold_on = 1'b1;
		repeat (300) @(posedge clk);
		hold_on = 1'b0;
	end

	// Overall time limit.
	initial begin : watchdog
		#2000000;
		$display("%0t: timed out with %0d words still due", $realtime, due_words.size());
		$display("Verification failed");
		$finish;
	end

	task automatic push_byte(input logic [7:0] data, input logic [1:0] ptype,
			input logic [FLEN_W-1:0] flen);
		byte_queue.push_back('{data, ptype, flen});
	endtask

	// Queue a whole frame; a noisy frame varies type and length after byte one.
	task automatic queue_frame(input int len, input logic [1:0] ptype, input bit noisy,
			inout int count);
		int n;
		n = (len == 0) ? 1 : len;
		for (int i = 0; i < n; i++) begin
			if (i > 0 && noisy)
				push_byte(8'($urandom), 2'($urandom), FLEN_W'($urandom));
			else
				push_byte(8'($urandom), ptype, FLEN_W'(len));
		end
		count += n;
	endtask

	// Wait until every queued byte is taken and every due word has come.
	task automatic wait_drained();
		@(posedge clk);
		while (byte_queue.size() != 0 || s_tvalid || due_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_MAX_PAYLOAD)
			max_payload_q = val[15:0];
		else
			ident_q = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [15:0] maxp, input logic [23:0] ident);
		write_reg(REG_MAX_PAYLOAD, {8'($urandom), maxp});
		write_reg(REG_CONFIG_IDENT, ident);
		settings++;
	endtask

	// Stimulus sequence.
	initial begin : stimulus
		int          count;
		int          maxlen;
		int          len;
		logic [15:0] maxp;
		logic [23:0] ident;
		count = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: single-byte frame and a zero-length frame.
		push_byte(8'h00, 2'd0, FLEN_W'(1));
		push_byte(8'hFF, 2'd3, FLEN_W'(0));
		wait_drained();

		// Three-byte packets: start, continuation and end fragments.
		set_regs(16'd3, 24'hFFFFFF);
		for (int i = 0; i < 7; i++)
			push_byte(i[0] ? 8'hFF : 8'h00, 2'd1, FLEN_W'(7));
		wait_drained();

		// Zero max_payload behaves as one byte per packet.
		set_regs(16'd0, 24'h000000);
		push_byte(8'hA5, 2'd2, FLEN_W'(2));
		push_byte(8'h5A, 2'd2, FLEN_W'(2));
		wait_drained();

		// max_payload and data type changed in the middle of a frame.
		set_regs(16'd4, 24'h123456);
		push_byte(8'h11, 2'd0, FLEN_W'(6));
		push_byte(8'h22, 2'd0, FLEN_W'(6));
		wait_drained();
		write_reg(REG_MAX_PAYLOAD, 24'd100);
		for (int i = 0; i < 4; i++)
			push_byte(8'($urandom), 2'd3, FLEN_W'($urandom));
		wait_drained();

		// Random phases, each with its own register setting; every third one runs without idling.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: maxp = 16'd1;
				1: maxp = 16'd0;
				2: maxp = 16'hFFFF;
				3: maxp = 16'($urandom_range(2, 5));
				4: maxp = 16'($urandom_range(6, 16));
				5: maxp = MAX_PAYLOAD_RST;
				6: maxp = 16'($urandom_range(2, 8));
				default: maxp = 16'($urandom_range(1, 12));
			endcase
			ident = (p == 0) ? 24'h000000 : (p == 1) ? 24'hFFFFFF : 24'($urandom);
			set_regs(maxp, ident);
			@(posedge clk);
			src_pct = (p % 3 == 0) ? 0 : $urandom_range(20, 50);
			snk_pct = (p % 3 == 0) ? 0 : $urandom_range(20, 50);
			maxlen = (maxp < 16'd8) ? 3 * int'(maxp) + 2 : 24;
			if (maxlen > 24)
				maxlen = 24;
			count = 0;
			while (count < 35) begin
				len = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, maxlen);
				queue_frame(len, 2'($urandom), $urandom_range(4) == 0, count);
			end
			wait_drained();
		end

		// Last part: no idling on either side.
		@(posedge clk);
		calm    = 1'b1;
		src_pct = 0;
		snk_pct = 0;
		set_regs(16'($urandom_range(3, 10)), 24'($urandom));
		count = 0;
		while (count < 35)
			queue_frame($urandom_range(1, 20), 2'($urandom), 1'b0, count);
		wait_drained();

		// Widest packet of the longest frame; the frame is left open.
		set_regs(16'hFFFF, 24'($urandom));
		for (int i = 0; i < 5; i++)
			push_byte(8'($urandom), 2'd3, {FLEN_W{1'b1}});
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d frame bytes under %0d register settings.", bytes_sent, settings);
		$display("Checked %0d words: %0d packet ends, %0d frame ends, %0d errors.",
			words_seen, packets_seen, frames_seen, errors);
		if (errors == 0 && due_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ theora_rtp_packetizer_core.f @@
hw/rtl/trp_pkg.sv
hw/rtl/trp_front.sv
hw/rtl/trp_fifo.sv
hw/rtl/trp_back.sv
hw/rtl/theora_rtp_packetizer_core.sv
bench/tb_theora_rtp_packetizer_core.sv
